FILE: src/lome_pkg.sv
package lome_pkg;

    localparam int NUM_INSTRUMENTS = 4;
    localparam int BOOK_DEPTH      = 16;
    localparam int NUM_CLIENTS     = 256;
    localparam int MAX_TRADES      = 32;

    localparam int INST_W  = $clog2(NUM_INSTRUMENTS);
    localparam int POS_W   = $clog2(BOOK_DEPTH);
    localparam int CNT_W   = $clog2(BOOK_DEPTH + 1);
    localparam int ADDR_W  = INST_W + POS_W;
    localparam int BOOK_N  = NUM_INSTRUMENTS * BOOK_DEPTH;
    localparam int CLI_W   = $clog2(NUM_CLIENTS);
    localparam int ROW_W   = 40;
    localparam int TRD_W   = $clog2(MAX_TRADES + 1);

    localparam logic [1:0] KIND_TRADE  = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic [15:0] price;
        logic [15:0] qty;
        logic [7:0]  client;
    } t_row;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  buyer;
        logic [7:0]  seller;
        logic [15:0] trade_quantity;
        logic [15:0] trade_price;
        logic [15:0] buyer_msg_no;
        logic [15:0] seller_msg_no;
        logic        last;
    } t_result;

endpackage

FILE: src/lome_ram.sv
module lome_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/limit_order_matching_engine_core.sv
// order flow: a full side gives a reject status; otherwise the insert shifts rows one by
//   one to make room, each match test reads both best rows, each trade updates the client
//   message counts, emits a trade item and pops filled rows, and a done status ends it
// throughput: one order at a time through the dual-port book and counter memories; the
//   next request is taken once the status item is registered
// reset: synchronous active low; counts cleared, market open, then 256 msg counters cleared
module limit_order_matching_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // instrument, price, quantity, client, pad
    input  logic        s_axis_tuser,  // is_buy
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // buyer, seller, trade_quantity, trade_price,
                                       // buyer_msg_no, seller_msg_no
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast
);
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CHK     = 4'd2;
    localparam logic [3:0] S_INS     = 4'd3;
    localparam logic [3:0] S_INS_CMP = 4'd4;
    localparam logic [3:0] S_MRD     = 4'd5;
    localparam logic [3:0] S_MCHK    = 4'd6;
    localparam logic [3:0] S_CRD1    = 4'd7;
    localparam logic [3:0] S_CRD2    = 4'd8;
    localparam logic [3:0] S_CRD3    = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;
    localparam logic [3:0] S_POPRD   = 4'd11;
    localparam logic [3:0] S_POPWR   = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0] r_state;
    logic r_open;
    logic [lome_pkg::CLI_W-1:0] r_clr;

    logic [lome_pkg::CNT_W-1:0] r_nb [lome_pkg::NUM_INSTRUMENTS];
    logic [lome_pkg::CNT_W-1:0] r_na [lome_pkg::NUM_INSTRUMENTS];

    logic [lome_pkg::INST_W-1:0] r_inst;
    logic r_buy;
    lome_pkg::t_row r_ord, r_b, r_a;
    logic [lome_pkg::CNT_W-1:0] r_pos;
    logic [lome_pkg::TRD_W-1:0] r_k;
    logic r_side;   // side being shifted or popped: 1 bid
    logic r_pop_b, r_pop_a, r_b_first;
    logic [15:0] r_first_no, r_sno, r_bno;

    lome_pkg::t_result r_out, out_next;
    logic r_ovalid;

    // book memories share address and data, each has its own write enable
    logic bid_we, ask_we;
    logic [lome_pkg::ADDR_W-1:0] row_wa, row_ra;
    lome_pkg::t_row row_wd, bid_rd, ask_rd;
    logic [lome_pkg::ROW_W-1:0] bid_rdv, ask_rdv;

    logic mc_we;
    logic [lome_pkg::CLI_W-1:0] mc_wa, mc_ra;
    logic [15:0] mc_wd, mc_rd;

    logic [lome_pkg::INST_W-1:0] in_inst;
    lome_pkg::t_row in_row;
    logic in_buy;
    logic [lome_pkg::CNT_W-1:0] cur_nb, cur_na, side_cnt;
    logic [lome_pkg::POS_W-1:0] pos_lo, pos_m1;
    lome_pkg::t_row side_rd;
    logic goes_before;
    logic side_full;
    logic [15:0] tq;
    logic [lome_pkg::CLI_W-1:0] b_ci, a_ci, first_ci, second_ci;
    logic [15:0] second_no;
    logic m_acc, out_free, out_load;
    logic do_match;

    lome_ram #(.WIDTH(lome_pkg::ROW_W), .DEPTH(lome_pkg::BOOK_N)) u_bid (
        .i_clk(i_clk), .i_we(bid_we), .i_waddr(row_wa), .i_wdata(row_wd),
        .i_raddr(row_ra), .o_rdata(bid_rdv));
    lome_ram #(.WIDTH(lome_pkg::ROW_W), .DEPTH(lome_pkg::BOOK_N)) u_ask (
        .i_clk(i_clk), .i_we(ask_we), .i_waddr(row_wa), .i_wdata(row_wd),
        .i_raddr(row_ra), .o_rdata(ask_rdv));
    assign bid_rd = bid_rdv;
    assign ask_rd = ask_rdv;

    lome_ram #(.WIDTH(16), .DEPTH(lome_pkg::NUM_CLIENTS)) u_msg (
        .i_clk(i_clk), .i_we(mc_we), .i_waddr(mc_wa), .i_wdata(mc_wd),
        .i_raddr(mc_ra), .o_rdata(mc_rd));

    assign in_inst = s_axis_tdata[lome_pkg::INST_W-1:0];
    assign in_buy  = s_axis_tuser;
    assign in_row  = {s_axis_tdata[17:2], s_axis_tdata[33:18], s_axis_tdata[41:34]};

    assign cur_nb   = r_nb[r_inst];
    assign cur_na   = r_na[r_inst];
    assign side_cnt = r_side ? cur_nb : cur_na;
    assign side_full = (r_buy ? cur_nb : cur_na) >=
                       lome_pkg::CNT_W'(lome_pkg::BOOK_DEPTH);

    assign pos_lo = r_pos[lome_pkg::POS_W-1:0];
    assign pos_m1 = pos_lo - lome_pkg::POS_W'(1);

    assign side_rd = r_side ? bid_rd : ask_rd;
    // new order moves ahead of the row at pos-1
    assign goes_before = r_side ? (r_ord.price > side_rd.price)
                                : (r_ord.price < side_rd.price);

    assign tq = (r_b.qty > r_a.qty) ? r_a.qty : r_b.qty;

    assign b_ci      = r_b.client[lome_pkg::CLI_W-1:0];
    assign a_ci      = r_a.client[lome_pkg::CLI_W-1:0];
    assign first_ci  = r_b_first ? b_ci : a_ci;
    assign second_ci = r_b_first ? a_ci : b_ci;
    // same client on both sides: first count is forwarded
    assign second_no = ((first_ci == second_ci) ? r_first_no : mc_rd) + 16'd1;

    assign do_match = r_open && (r_k < lome_pkg::TRD_W'(lome_pkg::MAX_TRADES)) &&
                      (cur_nb != '0) && (cur_na != '0) && (bid_rd.price >= ask_rd.price);

    assign m_acc    = m_axis_tvalid && m_axis_tready;
    assign out_free = !r_ovalid || m_acc;
    assign out_load = out_free && (((r_state == S_CHK) && side_full) ||
                                   (r_state == S_OUT) || (r_state == S_DONE));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out.seller_msg_no, r_out.buyer_msg_no, r_out.trade_price,
                            r_out.trade_quantity, r_out.seller, r_out.buyer};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    always_comb begin
        out_next = '0;
        out_next.last = 1'b1;
        case (r_state)
            S_OUT: begin
                out_next.kind           = lome_pkg::KIND_TRADE;
                out_next.buyer          = r_b.client;
                out_next.seller         = r_a.client;
                out_next.trade_quantity = tq;
                out_next.trade_price    = r_a.price;
                out_next.buyer_msg_no   = r_bno;
                out_next.seller_msg_no  = r_sno;
                out_next.last           = 1'b0;
            end
            S_CHK: out_next.kind = lome_pkg::KIND_REJECT;
            default: out_next.kind = lome_pkg::KIND_DONE;
        endcase
    end

    always_comb begin
        bid_we = 1'b0;
        ask_we = 1'b0;
        row_wa = {r_inst, pos_lo};
        row_wd = r_ord;
        row_ra = {r_inst, pos_m1};
        mc_we  = 1'b0;
        mc_wa  = r_clr;
        mc_wd  = 16'd0;
        mc_ra  = first_ci;
        case (r_state)
            S_CLR: mc_we = 1'b1;
            S_INS: begin
                if (r_pos == '0) begin
                    bid_we = r_side;
                    ask_we = !r_side;
                end
            end
            S_INS_CMP: begin
                bid_we = r_side;
                ask_we = !r_side;
                if (goes_before) row_wd = side_rd;
            end
            S_MRD: row_ra = {r_inst, {lome_pkg::POS_W{1'b0}}};
            S_CRD2: begin
                mc_ra = second_ci;
                mc_we = 1'b1;
                mc_wa = first_ci;
                mc_wd = mc_rd + 16'd1;
            end
            S_CRD3: begin
                mc_we = 1'b1;
                mc_wa = second_ci;
                mc_wd = second_no;
            end
            S_OUT: begin
                // partly filled best row is written back
                row_wa = {r_inst, {lome_pkg::POS_W{1'b0}}};
                if (!r_pop_b) begin
                    row_wd = '{price: r_b.price, qty: r_b.qty - r_a.qty, client: r_b.client};
                    bid_we = out_free;
                end else if (!r_pop_a) begin
                    row_wd = '{price: r_a.price, qty: r_a.qty - r_b.qty, client: r_a.client};
                    ask_we = out_free;
                end
            end
            S_POPRD: row_ra = {r_inst, pos_lo};
            S_POPWR: begin
                row_wa = {r_inst, pos_m1};
                row_wd = side_rd;
                bid_we = r_side;
                ask_we = !r_side;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_open   <= 1'b1;
            r_ovalid <= 1'b0;
            for (int i = 0; i < lome_pkg::NUM_INSTRUMENTS; i++) begin
                r_nb[i] <= '0;
                r_na[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_open <= i_cfg_wdata;
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_out    <= out_next;
            end else if (m_acc) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + lome_pkg::CLI_W'(1);
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_inst  <= in_inst;
                        r_buy   <= in_buy;
                        r_side  <= in_buy;
                        r_ord   <= in_row;
                        r_k     <= '0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (side_full) begin
                        if (out_free) r_state <= S_IDLE;
                    end else begin
                        r_pos   <= r_buy ? cur_nb : cur_na;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    if (r_pos == '0) begin
                        if (r_side) r_nb[r_inst] <= cur_nb + lome_pkg::CNT_W'(1);
                        else r_na[r_inst] <= cur_na + lome_pkg::CNT_W'(1);
                        r_state <= S_MRD;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (goes_before) begin
                        r_pos   <= r_pos - lome_pkg::CNT_W'(1);
                        r_state <= S_INS;
                    end else begin
                        if (r_side) r_nb[r_inst] <= cur_nb + lome_pkg::CNT_W'(1);
                        else r_na[r_inst] <= cur_na + lome_pkg::CNT_W'(1);
                        r_state <= S_MRD;
                    end
                end
                S_MRD: r_state <= S_MCHK;
                S_MCHK: begin
                    r_b       <= bid_rd;
                    r_a       <= ask_rd;
                    r_b_first <= bid_rd.qty < ask_rd.qty;
                    r_pop_b   <= bid_rd.qty <= ask_rd.qty;
                    r_pop_a   <= bid_rd.qty >= ask_rd.qty;
                    if (do_match) r_state <= S_CRD1;
                    else r_state <= S_DONE;
                end
                S_CRD1: r_state <= S_CRD2;
                S_CRD2: begin
                    r_first_no <= mc_rd + 16'd1;
                    r_state    <= S_CRD3;
                end
                S_CRD3: begin
                    if (r_b_first) begin
                        r_bno <= r_first_no;
                        r_sno <= second_no;
                    end else begin
                        r_sno <= r_first_no;
                        r_bno <= second_no;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_k     <= r_k + lome_pkg::TRD_W'(1);
                        r_side  <= r_pop_b;
                        r_pos   <= lome_pkg::CNT_W'(1);
                        r_state <= S_POPRD;
                    end
                end
                S_POPRD: begin
                    if (r_pos >= side_cnt) begin
                        if (r_side) begin
                            r_nb[r_inst] <= cur_nb - lome_pkg::CNT_W'(1);
                            if (r_pop_a) begin
                                r_side <= 1'b0;
                                r_pos  <= lome_pkg::CNT_W'(1);
                            end else begin
                                r_state <= S_MRD;
                            end
                        end else begin
                            r_na[r_inst] <= cur_na - lome_pkg::CNT_W'(1);
                            r_state <= S_MRD;
                        end
                    end else begin
                        r_state <= S_POPWR;
                    end
                end
                S_POPWR: begin
                    r_pos   <= r_pos + lome_pkg::CNT_W'(1);
                    r_state <= S_POPRD;
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser) && $stable(m_axis_tlast));
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= lome_pkg::KIND_REJECT);
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != lome_pkg::KIND_TRADE)));
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !s_axis_tready);
endmodule
